// ===== rtl/core/ambient_light_backlight_controller_assert.svh =====
// Assertion macros for the backlight controller modules (used by the datapath).
// Both expect signals named clock and reset in the using module.
`ifndef AMBIENT_LIGHT_BACKLIGHT_CONTROLLER_ASSERT_SVH
`define AMBIENT_LIGHT_BACKLIGHT_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define ALB_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ALB_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/alb_pkg.sv =====
`timescale 1ns / 1ps
package alb_pkg;

   localparam int LUX_W      = 17;
   localparam int LEVEL_W    = 7;
   localparam int DUTY_W     = 16;
   localparam int PERIOD_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam int MANT_BITS  = 30;
   localparam int EXP_W      = 5;
   localparam int RECIP_SHIFT = 30;

   localparam logic [LEVEL_W-1:0] PCT_MAX   = 7'd100;
   localparam logic [23:0]        RECIP_MUL = 24'd10737419;  // ceil(2^30 / 100)

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_MAX     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_ON   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_PERIOD  = 2'd3;

   localparam logic [LUX_W-1:0]    RAW_MAX_RESET = 17'd100000;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'd30518;

   typedef struct packed {
      logic take;
      logic man_load;
      logic avg_update;
      logic log_load_num;
      logic log_load_den;
      logic norm_step;
      logic mant_load;
      logic sq_step;
      logic store_num;
      logic store_den;
      logic div_load;
      logic div_step;
      logic target_write;
      logic mul1;
      logic mul2;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic action;
      logic auto_enable;
      logic screen_on;
      logic norm_done;
      logic take_target;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/alb_if.sv =====
`timescale 1ns / 1ps
interface alb_req_if;
   import alb_pkg::*;
   logic               valid;
   logic               ready;
   logic               action;
   logic [LUX_W-1:0]   lux_raw;
   logic [LEVEL_W-1:0] requested_level;
   modport source (output valid, action, lux_raw, requested_level, input ready);
   modport sink   (input valid, action, lux_raw, requested_level, output ready);
endinterface

interface alb_rsp_if;
   import alb_pkg::*;
   logic               valid;
   logic               ready;
   logic [DUTY_W-1:0]  duty_ns;
   logic [LEVEL_W-1:0] brightness;
   logic               from_manual;
   modport source (output valid, duty_ns, brightness, from_manual, input ready);
   modport sink   (input valid, duty_ns, brightness, from_manual, output ready);
endinterface

interface alb_csr_if;
   import alb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/alb_datapath.sv =====
`timescale 1ns / 1ps
`include "ambient_light_backlight_controller_assert.svh"
module alb_datapath #(
   parameter int FRACTION_BITS     = 8,
   parameter int LOG_FRACTION_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  alb_pkg::cmd_type                 cmd,
   output alb_pkg::status_type              status,
   input  logic                             req_action,
   input  logic [alb_pkg::LUX_W-1:0]        req_lux_raw,
   input  logic [alb_pkg::LEVEL_W-1:0]      req_level,
   input  logic                             csr_write,
   input  logic [alb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [alb_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [alb_pkg::DUTY_W-1:0]       rsp_duty_ns,
   output logic [alb_pkg::LEVEL_W-1:0]      rsp_brightness,
   output logic                             rsp_from_manual
);
   import alb_pkg::*;

   localparam int F  = FRACTION_BITS;
   localparam int L  = LOG_FRACTION_BITS;
   localparam int AW = LUX_W + F;
   localparam int XW = AW + 1;
   localparam int NW = $clog2(XW);
   localparam int LW = EXP_W + L;
   localparam int DW = LW + 9;
   localparam int MW = MANT_BITS + 1;

   // captured item and registers
   logic                action_ff;
   logic [LUX_W-1:0]    lux_ff;
   logic [LEVEL_W-1:0]  level_ff;
   logic [LUX_W-1:0]    raw_max_ff;
   logic                auto_ff, screen_ff;
   logic [PERIOD_W-1:0] period_ff;

   // state
   logic [AW-1:0]       avg_ff;
   logic                avg_seeded_ff;
   logic [LEVEL_W-1:0]  last_ff;
   logic                tseed_ff;

   // log unit
   logic [XW-1:0]       x_ff;
   logic [NW-1:0]       n_ff;
   logic [MW-1:0]       m_ff;
   logic [L-1:0]        frac_ff;
   logic [LW-1:0]       num_ff, den_ff;

   // divider
   logic [DW-1:0]       dvd_ff;
   logic [LW:0]         rem_ff;

   // result build
   logic [LEVEL_W-1:0]  pct_ff;
   logic                manual_ff;
   logic [22:0]         prod1_ff;
   logic [DUTY_W-1:0]   duty_ff;
   logic                rsp_valid_ff;
   logic [DUTY_W-1:0]   rsp_duty_ff;
   logic [LEVEL_W-1:0]  rsp_pct_ff;
   logic                rsp_man_ff;

   logic [AW-1:0]        scaled;
   logic [AW+1:0]        avg_sum;
   logic [AW-1:0]        avg_in;
   logic [LUX_W-1:0]     rm;
   logic [XW-1:0]        num_arg, den_arg;
   logic [XW+MANT_BITS:0] ext;
   logic [MW-1:0]        mant_in;
   logic [2*MW-1:0]      sq;
   logic [MW:0]          sq_top;
   logic [NW-1:0]        exp_num;
   logic [LW-1:0]        log_num, log_den;
   logic [LW:0]          dsr;
   logic [LW+1:0]        r2;
   logic                 ge;
   logic [LEVEL_W-1:0]   pct_calc, diff, lvl_clamp;
   logic [46:0]          prod2;

   // average update
   assign scaled  = {lux_ff, F'(0)};
   assign avg_sum = {2'b0, scaled} + {2'b0, avg_ff} + {1'b0, avg_ff, 1'b0};
   assign avg_in  = avg_seeded_ff ? avg_sum[AW+1:2] : scaled;

   // log arguments
   assign rm      = (raw_max_ff == '0) ? LUX_W'(1) : raw_max_ff;
   assign num_arg = {1'b0, avg_ff} + (XW'(1) << F);
   assign den_arg = XW'(rm) + XW'(1);

   // mantissa alignment and squaring
   assign ext     = {x_ff, MW'(0)};
   assign mant_in = ext[XW+MANT_BITS -: MW];
   assign sq      = m_ff * m_ff;
   assign sq_top  = sq[2*MW-1:MANT_BITS];

   assign exp_num = n_ff - NW'(F);
   assign log_num = (n_ff < NW'(F)) ? '0 : {exp_num[EXP_W-1:0], frac_ff};
   assign log_den = {n_ff[EXP_W-1:0], frac_ff};

   // restoring division step
   assign dsr = (den_ff == '0) ? (LW+1)'(2) : {den_ff, 1'b0};
   assign r2  = {rem_ff, dvd_ff[DW-1]};
   assign ge  = r2 >= {1'b0, dsr};

   // percent and target decision
   assign pct_calc  = (dvd_ff > DW'(PCT_MAX)) ? PCT_MAX : dvd_ff[LEVEL_W-1:0];
   assign diff      = (pct_calc > last_ff) ? pct_calc - last_ff : last_ff - pct_calc;
   assign lvl_clamp = (level_ff > PCT_MAX) ? PCT_MAX : level_ff;
   assign prod2     = 47'(prod1_ff) * 47'(RECIP_MUL);

   assign status.action      = action_ff;
   assign status.auto_enable = auto_ff;
   assign status.screen_on   = screen_ff;
   assign status.norm_done   = x_ff[XW-1];
   assign status.take_target = auto_ff && (!tseed_ff || (diff >= LEVEL_W'(2)));
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_max_ff    <= RAW_MAX_RESET;
         auto_ff       <= 1'b0;
         screen_ff     <= 1'b1;
         period_ff     <= PERIOD_RESET;
         avg_ff        <= '0;
         avg_seeded_ff <= 1'b0;
         last_ff       <= '0;
         tseed_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_RAW_MAX:     raw_max_ff <= csr_data;
               CSR_AUTO_ENABLE: auto_ff    <= csr_data[0];
               CSR_SCREEN_ON:   screen_ff  <= csr_data[0];
               CSR_PWM_PERIOD:  period_ff  <= csr_data[PERIOD_W-1:0];
               default: ;
            endcase
         end
         if (cmd.avg_update) begin
            avg_ff        <= avg_in;
            avg_seeded_ff <= 1'b1;
         end
         if (cmd.target_write) begin
            last_ff  <= pct_calc;
            tseed_ff <= 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload datapath
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         action_ff <= req_action;
         lux_ff    <= req_lux_raw;
         level_ff  <= req_level;
      end
      if (cmd.log_load_num) begin
         x_ff <= num_arg;
         n_ff <= NW'(XW - 1);
      end else if (cmd.log_load_den) begin
         x_ff <= den_arg;
         n_ff <= NW'(XW - 1);
      end else if (cmd.norm_step) begin
         x_ff <= {x_ff[XW-2:0], 1'b0};
         n_ff <= n_ff - NW'(1);
      end
      if (cmd.mant_load) begin
         m_ff    <= mant_in;
         frac_ff <= '0;
      end else if (cmd.sq_step) begin
         m_ff    <= sq_top[MW] ? sq_top[MW:1] : sq_top[MW-1:0];
         frac_ff <= {frac_ff[L-2:0], sq_top[MW]};
      end
      if (cmd.store_num) num_ff <= log_num;
      if (cmd.store_den) den_ff <= log_den;
      if (cmd.div_load) begin
         dvd_ff <= DW'(num_ff) * DW'(200) + DW'(den_ff);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? (LW+1)'(r2 - {1'b0, dsr}) : r2[LW:0];
         dvd_ff <= {dvd_ff[DW-2:0], ge};
      end
      if (cmd.target_write) begin
         pct_ff    <= pct_calc;
         manual_ff <= 1'b0;
      end else if (cmd.man_load) begin
         pct_ff    <= lvl_clamp;
         manual_ff <= 1'b1;
      end
      if (cmd.mul1) prod1_ff <= 23'(PCT_MAX - pct_ff) * 23'(period_ff);
      if (cmd.mul2) duty_ff  <= prod2[RECIP_SHIFT+DUTY_W-1:RECIP_SHIFT];
      if (cmd.out_load) begin
         rsp_duty_ff <= duty_ff;
         rsp_pct_ff  <= pct_ff;
         rsp_man_ff  <= manual_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_duty_ns     = rsp_duty_ff;
   assign rsp_brightness  = rsp_pct_ff;
   assign rsp_from_manual = rsp_man_ff;

   `ALB_ASSERT_IMP(a_rsp_range, rsp_valid_ff, rsp_pct_ff <= PCT_MAX, "brightness above 100")
   `ALB_ASSERT_NXT(a_mant_norm, cmd.mant_load || cmd.sq_step, m_ff[MANT_BITS],
                   "mantissa lost normalization")
   `ALB_ASSERT_IMP(a_norm_live, cmd.norm_step, x_ff != '0, "normalizing a zero argument")
   `ALB_ASSERT_NXT(a_target_set, cmd.target_write, tseed_ff && last_ff <= PCT_MAX,
                   "target not recorded")

endmodule

// ===== rtl/core/alb_controller.sv =====
`timescale 1ns / 1ps
module alb_controller #(
   parameter int SQ_STEPS  = 16,
   parameter int DIV_STEPS = 30
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  alb_pkg::status_type status,
   output alb_pkg::cmd_type    cmd
);
   import alb_pkg::*;

   localparam int CW = $clog2(DIV_STEPS + SQ_STEPS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_LOAD_NUM, S_NORM, S_SQ, S_STORE,
      S_DIV_LOAD, S_DIV, S_DECIDE, S_MUL1, S_MUL2, S_OUT
   } state_type;

   state_type     state_ff, state_in;
   logic          ready_ff, ready_in;
   logic          den_sel_ff, den_sel_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // decode commands and next state
   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      ready_in   = 1'b0;
      den_sel_in = den_sel_ff;
      cnt_in     = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            ready_in = 1'b1;
            if (req_valid && ready_ff) begin
               cmd.take = 1'b1;
               ready_in = 1'b0;
               state_in = S_START;
            end
         end
         S_START: begin
            if (status.action) begin
               if (status.auto_enable) begin
                  state_in = S_IDLE;
                  ready_in = 1'b1;
               end else begin
                  cmd.man_load = 1'b1;
                  state_in     = S_MUL1;
               end
            end else begin
               cmd.avg_update = 1'b1;
               state_in       = S_LOAD_NUM;
            end
         end
         S_LOAD_NUM: begin
            cmd.log_load_num = 1'b1;
            den_sel_in       = 1'b0;
            state_in         = S_NORM;
         end
         S_NORM: begin
            if (status.norm_done) begin
               cmd.mant_load = 1'b1;
               cnt_in        = '0;
               state_in      = S_SQ;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         S_SQ: begin
            cmd.sq_step = 1'b1;
            cnt_in      = cnt_ff + CW'(1);
            if (cnt_ff == CW'(SQ_STEPS - 1)) state_in = S_STORE;
         end
         S_STORE: begin
            if (den_sel_ff) begin
               cmd.store_den = 1'b1;
               state_in      = S_DIV_LOAD;
            end else begin
               cmd.store_num    = 1'b1;
               cmd.log_load_den = 1'b1;
               den_sel_in       = 1'b1;
               state_in         = S_NORM;
            end
         end
         S_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DIV_STEPS - 1)) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (status.take_target) begin
               cmd.target_write = 1'b1;
               if (status.screen_on) begin
                  state_in = S_MUL1;
               end else begin
                  state_in = S_IDLE;
                  ready_in = 1'b1;
               end
            end else begin
               state_in = S_IDLE;
               ready_in = 1'b1;
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
               ready_in     = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ready_ff   <= 1'b0;
         den_sel_ff <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         ready_ff   <= ready_in;
         den_sel_ff <= den_sel_in;
         cnt_ff     <= cnt_in;
      end
   end

   assign req_ready = ready_ff && (state_ff == S_IDLE);

endmodule

// ===== rtl/core/ambient_light_backlight_controller.sv =====
`timescale 1ns / 1ps
// Ambient light backlight controller.
// req_bus carries one item per transfer: a sensor sample (action 0, lux_raw)
// or a manual brightness request (action 1, requested_level).
// rsp_bus returns at most one result per item: duty_ns, brightness and
// from_manual. csr_bus writes raw_max, auto_enable, screen_on and pwm_period
// by index; it is always ready and must only be written while idle.
// A sample runs through a moving-average update, two base-2 logarithms on one
// shared unit (bit-by-bit normalize, then LOG_FRACTION_BITS squaring steps),
// a restoring divider of LOG_FRACTION_BITS+14 steps and, when a new target is
// taken with the screen on, a two-stage duty multiply. A manual request skips
// the logarithms and the divider and goes straight to the duty multiply; while
// auto_enable is set it gives no result.
// One item is in flight at a time; req ready rises again once the item is
// done, for an item with a result once it sits in the output register, so
// the next item may enter while the result waits. If the receiver stalls with
// a result still held, the next result waits in the controller until the
// output register frees.
// Synchronous reset returns registers to their reset values, clears the
// average and the last target and empties the output register.
module ambient_light_backlight_controller #(
   parameter int FRACTION_BITS     = 8,
   parameter int LOG_FRACTION_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   alb_req_if.sink    req_bus,
   alb_rsp_if.source  rsp_bus,
   alb_csr_if.sink    csr_bus
);
   import alb_pkg::*;

   localparam int DIV_STEPS = EXP_W + LOG_FRACTION_BITS + 9;

   cmd_type    cmd;
   status_type status;

   assign csr_bus.ready = 1'b1;

   alb_controller #(
      .SQ_STEPS  (LOG_FRACTION_BITS),
      .DIV_STEPS (DIV_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   alb_datapath #(
      .FRACTION_BITS     (FRACTION_BITS),
      .LOG_FRACTION_BITS (LOG_FRACTION_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_action      (req_bus.action),
      .req_lux_raw     (req_bus.lux_raw),
      .req_level       (req_bus.requested_level),
      .csr_write       (csr_bus.valid),
      .csr_index       (csr_bus.index),
      .csr_data        (csr_bus.data),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_duty_ns     (rsp_bus.duty_ns),
      .rsp_brightness  (rsp_bus.brightness),
      .rsp_from_manual (rsp_bus.from_manual)
   );

endmodule

// ===== tb/sv/tb_ambient_light_backlight_controller.sv =====
`timescale 1ns / 1ps
module tb_ambient_light_backlight_controller;
   import alb_pkg::*;

   typedef struct packed {
      logic [DUTY_W-1:0]  duty_ns;
      logic [LEVEL_W-1:0] brightness;
      logic               from_manual;
   } backlight_out_type;

   logic clock;
   logic reset;

   alb_req_if req_bus ();
   alb_rsp_if rsp_bus ();
   alb_csr_if csr_bus ();

   ambient_light_backlight_controller dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   // shadow registers and state
   logic [16:0] sh_raw_max;
   logic        sh_auto, sh_screen;
   logic [15:0] sh_period;
   logic [24:0] avg_level;
   logic        avg_seeded;
   logic [6:0]  last_target;
   logic        target_seeded;

   backlight_out_type pending_levels[$];
   int mismatches;
   int results_seen;
   int drain_stall;
   bit idle_off;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #80ms;
      $display("DONE: errors detected");
      $finish;
   end

   // base-2 log in fixed point, 16 fraction bits
   function automatic longint unsigned log2_q16(longint unsigned v, int f);
      int n;
      longint unsigned m, t, frac;
      n = 0;
      frac = 0;
      t = v;
      if (v == 0) return 0;
      while (t > 1) begin
         t >>= 1;
         n++;
      end
      if (n <= MANT_BITS) m = v << (MANT_BITS - n);
      else m = v >> (n - MANT_BITS);
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> MANT_BITS;
         frac <<= 1;
         if (m >= (64'd1 << (MANT_BITS + 1))) begin
            frac |= 1;
            m >>= 1;
         end
      end
      if (n < f) return 0;
      return (longint'(n - f) << 16) | frac;
   endfunction

   function automatic backlight_out_type duty_for(int p, bit manual);
      backlight_out_type o;
      longint unsigned d;
      d = (longint'(100 - p) * sh_period) / 100;
      o.duty_ns = d[15:0];
      o.brightness = p[6:0];
      o.from_manual = manual;
      return o;
   endfunction

   // append one expected result at the tail
   function automatic void expect_result(backlight_out_type o);
      pending_levels = {pending_levels, o};
   endfunction

   // advance the shadow state for one item; queue any result
   task automatic predict_backlight(bit action, logic [16:0] lux, logic [6:0] lvl);
      longint unsigned sc, rm, num, den, p;
      int pc, diff;
      if (action == 1'b0) begin
         sc = longint'(lux) << 8;
         rm = (sh_raw_max == 0) ? 1 : sh_raw_max;
         if (!avg_seeded) begin
            avg_level = 25'(sc);
            avg_seeded = 1'b1;
         end else begin
            avg_level = 25'((sc + 3 * longint'(avg_level)) >> 2);
         end
         num = log2_q16(longint'(avg_level) + 256, 8);
         den = log2_q16(rm + 1, 0);
         if (den == 0) den = 1;
         p = (200 * num + den) / (2 * den);
         if (p > 100) p = 100;
         pc = int'(p);
         if (!sh_auto) return;
         diff = (pc > last_target) ? pc - last_target : last_target - pc;
         if (target_seeded && diff < 2) return;
         last_target = pc[6:0];
         target_seeded = 1'b1;
         if (!sh_screen) return;
         expect_result(duty_for(pc, 1'b0));
      end else begin
         if (sh_auto) return;
         expect_result(duty_for((lvl > 100) ? 100 : lvl, 1'b1));
      end
   endtask

   // send one item, with random idle cycles before it
   task automatic send_item(bit action, logic [16:0] lux, logic [6:0] lvl);
      while (!idle_off && $urandom_range(99) < 23) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= action;
      req_bus.lux_raw <= lux;
      req_bus.requested_level <= lvl;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_backlight(action, lux, lvl);
   endtask

   // write one register while the block is idle
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [16:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_RAW_MAX:     sh_raw_max = val;
         CSR_AUTO_ENABLE: sh_auto = val[0];
         CSR_SCREEN_ON:   sh_screen = val[0];
         CSR_PWM_PERIOD:  sh_period = val[15:0];
         default: ;
      endcase
   endtask

   // wait for all results, then for an in-flight sample with no result
   task automatic settle();
      int n;
      n = 0;
      req_bus.valid <= 1'b0;
      while (pending_levels.size() != 0 && n < 200000) begin
         @(posedge clock);
         n++;
      end
      repeat (300) @(posedge clock);
   endtask

   task automatic configure(logic [16:0] rmax, bit ae, bit so, logic [15:0] per);
      settle();
      write_reg(CSR_RAW_MAX, rmax);
      write_reg(CSR_AUTO_ENABLE, ae);
      write_reg(CSR_SCREEN_ON, so);
      write_reg(CSR_PWM_PERIOD, per);
      csr_bus.valid <= 1'b0;
   endtask

   // random sensor value, weighted toward small and edge readings
   function automatic logic [16:0] rand_lux();
      case ($urandom_range(5))
         0: return 17'd0;
         1: return 17'h1FFFF;
         2: return 17'($urandom_range(255));
         default: return 17'($urandom);
      endcase
   endfunction

   task automatic test_manual_levels();
      configure(17'd100000, 1'b0, 1'b1, 16'd30518);
      send_item(1'b1, 17'd0, 7'd0);
      send_item(1'b1, 17'h1FFFF, 7'd100);
      send_item(1'b1, 17'd0, 7'd101);
      send_item(1'b1, 17'd5, 7'd127);
      send_item(1'b1, 17'd0, 7'd55);
      send_item(1'b0, 17'd1000, 7'h7F);
   endtask

   task automatic test_auto_extremes();
      configure(17'd0, 1'b1, 1'b1, 16'd65535);
      send_item(1'b0, 17'd0, 7'd0);
      send_item(1'b0, 17'h1FFFF, 7'd0);
      send_item(1'b1, 17'd0, 7'd50);
      configure(17'h1FFFF, 1'b1, 1'b1, 16'd0);
      send_item(1'b0, 17'h1FFFF, 7'd0);
      send_item(1'b0, 17'h1FFFF, 7'd0);
      send_item(1'b0, 17'd0, 7'd0);
      configure(17'd1, 1'b1, 1'b0, 16'd1);
      send_item(1'b0, 17'd3, 7'd0);
      send_item(1'b0, 17'd0, 7'd0);
      configure(17'd1, 1'b1, 1'b1, 16'd1);
      send_item(1'b0, 17'd0, 7'd0);
      send_item(1'b0, 17'd1, 7'd0);
   endtask

   task automatic test_random_mix(int count, logic [16:0] rmax, bit ae, bit so,
                                  logic [15:0] per);
      configure(rmax, ae, so, per);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0)
            send_item(1'b1, 17'($urandom), 7'($urandom));
         else
            send_item(1'b0, rand_lux(), 7'($urandom));
      end
   endtask

   task automatic test_backpressure();
      configure(17'd4000, 1'b0, 1'b1, 16'd12345);
      drain_stall = 400;
      for (int i = 0; i < 12; i++) send_item(1'b1, 17'($urandom), 7'($urandom));
   endtask

   // receiver: random stalls, compare each transfer against the oldest one
   initial begin
      backlight_out_type got, want;
      rsp_bus.ready = 1'b0;
      mismatches = 0;
      results_seen = 0;
      drain_stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.duty_ns, rsp_bus.brightness, rsp_bus.from_manual};
            results_seen++;
            if (pending_levels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
               want = pending_levels.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
               end
            end
         end
         if (drain_stall > 0) begin
            drain_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= idle_off ? 1'b1 : ($urandom_range(99) >= 23);
         end
      end
   end

   initial begin
      reset = 1'b1;
      idle_off = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.action = 1'b0;
      req_bus.lux_raw = '0;
      req_bus.requested_level = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_RAW_MAX;
      csr_bus.data = '0;
      sh_raw_max = RAW_MAX_RESET;
      sh_auto = 1'b0;
      sh_screen = 1'b1;
      sh_period = PERIOD_RESET;
      avg_level = '0;
      avg_seeded = 1'b0;
      last_target = '0;
      target_seeded = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_manual_levels();
      test_auto_extremes();
      test_backpressure();
      test_random_mix(180, 17'd100000, 1'b1, 1'b1, 16'd30518);
      test_random_mix(120, 17'($urandom_range(1, 131071)), 1'b0, 1'b1, 16'($urandom));
      test_random_mix(100, 17'd255, 1'b1, 1'b0, 16'd999);
      idle_off = 1'b1;
      test_random_mix(120, 17'h1FFFF, 1'b1, 1'b1, 16'd65535);
      idle_off = 1'b0;
      test_random_mix(110, 17'($urandom_range(1, 2000)), 1'b1, 1'b1,
                      16'($urandom_range(1, 65535)));

      settle();
      $display("Covered manual clamping, auto targets with hysteresis, screen off,");
      $display("register extremes and output back-pressure; %0d results checked.",
               results_seen);
      if (mismatches == 0 && pending_levels.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ===== ambient_light_backlight_controller.f =====
+incdir+rtl/core
rtl/core/alb_pkg.sv
rtl/core/alb_if.sv
rtl/core/alb_datapath.sv
rtl/core/alb_controller.sv
rtl/core/ambient_light_backlight_controller.sv
tb/sv/tb_ambient_light_backlight_controller.sv
